>>> design/sobv_pkg.sv
// sobv_pkg: shared widths, register codes, reset values and the tap type
// for the vertical sobel gradient stream; no dependencies
package sobv_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned LEN_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned MIN_DIM        = 3;

  localparam logic [DIM_W-1:0] ROW_SAT     = 11'd2047;
  localparam logic [DIM_W-1:0] DEF_WIDTH   = 11'd640;
  localparam logic [DIM_W-1:0] DEF_HEIGHT  = 11'd480;
  localparam logic [IDX_W-1:0] DEF_START   = 20'd0;
  localparam logic [LEN_W-1:0] DEF_LENGTH  = 21'h100000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LENGTH = 2'd3;

  // one window column: upper row and lower row pixel
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
  } tap_t;

  // clamp a frame dimension to MIN_DIM..hi
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned hi);
    logic [DIM_W-1:0] res;
    if (int'(v) < int'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (int'(v) > int'(hi)) begin
      res = DIM_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> design/sobv_if.sv
// sobv_if: valid/ready stream interfaces for pixel items and result items
// depends on sobv_pkg for the field widths
interface sobv_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sobv_pkg::PIX_W-1:0]  grey_level;
  logic                        frame_start;

  modport source (output valid, output grey_level, output frame_start, input ready);
  modport sink   (input valid, input grey_level, input frame_start, output ready);
endinterface

interface sobv_res_if;
  logic                        valid;
  logic                        ready;
  logic [sobv_pkg::IDX_W-1:0]  pixel_index;
  logic [sobv_pkg::PIX_W-1:0]  gradient_byte;
  logic                        written;

  modport source (output valid, output pixel_index, output gradient_byte,
                  output written, input ready);
  modport sink   (input valid, input pixel_index, input gradient_byte,
                  input written, output ready);
endinterface

>>> design/sobel_vertical_gradient_stream.sv
// sobel_vertical_gradient_stream: streaming 3x3 vertical sobel gradient
// depends on sobv_pkg, sobv_if, sobv_line_store and sobv_tap_cell
//
// usage
//   pix_i carries grey pixels in raster order; frame_start marks index 0 of
//   a frame. res_o carries one result item per pixel once the window centre
//   exists: the centre lags the input by one row plus one pixel, so the
//   first frame_width+1 pixels of a stream give no result.
//   each result has the raster index of the centre, the low byte of
//   2*up + upleft + upright - 2*down - downleft - downright, and written,
//   which is low (and the byte zero) for border or out-of-range centres.
//   cfg_*_i writes frame_width, frame_height, range_start, range_length;
//   write only while no item is in flight. dimensions are clamped on write.
// timing
//   one item per cycle sustained while res_o.ready holds. an accepted item reads
//   both line stores (registered read) at its accept edge; in stage 1 it does
//   the arithmetic and writes back once the output register can take it, at
//   the edge that loads its result there; res_o.valid rises after that edge.
// reset and stall
//   reset clears counters, window taps and the pipeline valids; config
//   returns to 640x480 with the full index range. line stores hold no reset.
//   a stalled receiver holds the output register; the compute stage and
//   then pix_i.ready back up behind it, with nothing dropped.
module sobel_vertical_gradient_stream #(
  parameter int unsigned MAX_WIDTH  = sobv_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sobv_pix_if.sink                        pix_i,
  sobv_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [sobv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sobv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sobv_pkg::*;

  // row width never exceeds what the 11-bit width register can hold
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);

  // ---------------------------------------------------------------
  // configuration (stored already clamped)
  // ---------------------------------------------------------------
  logic [DIM_W-1:0] width_q, height_q;
  logic [IDX_W-1:0] start_q;
  logic [LEN_W-1:0] length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_dim(DEF_WIDTH, MAX_WIDTH);
      height_q <= clamp_dim(DEF_HEIGHT, MAX_HEIGHT);
      start_q  <= DEF_START;
      length_q <= DEF_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_data_i[DIM_W-1:0], MAX_WIDTH);
        REG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_data_i[DIM_W-1:0], MAX_HEIGHT);
        REG_RANGE_START:  start_q  <= cfg_data_i[IDX_W-1:0];
        REG_RANGE_LENGTH: length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // handshake control
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, s1_fire, accept;

  assign s1_adv      = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  // ---------------------------------------------------------------
  // stage 0: position counters, line store read address
  // ---------------------------------------------------------------
  logic [IDX_W-1:0] pc_q, pc_base, centre0;
  logic [DIM_W-1:0] col_q, col_base, x0;
  logic [DIM_W-1:0] row_q, row_base, r0;
  logic             new_row, emit0;

  always_comb begin
    pc_base  = pix_i.frame_start ? '0 : pc_q;
    col_base = pix_i.frame_start ? '0 : col_q;
    row_base = pix_i.frame_start ? '0 : row_q;
    // a column count at or past the width (also after a width change) wraps
    new_row  = col_base >= width_q;
    x0       = new_row ? '0 : col_base;
    if (new_row && (row_base != ROW_SAT)) begin
      r0 = row_base + DIM_W'(1);
    end else begin
      r0 = row_base;
    end
    emit0   = (r0 >= DIM_W'(2)) || ((r0 == DIM_W'(1)) && (x0 != '0));
    centre0 = pc_base - IDX_W'(width_q) - IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      pc_q  <= pc_base + IDX_W'(1);
      col_q <= x0 + DIM_W'(1);
      row_q <= r0;
    end
  end

  // ---------------------------------------------------------------
  // stage 1 registers
  // ---------------------------------------------------------------
  logic [DIM_W-1:0] s1_x_q, s1_r_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_emit_q;
  logic [IDX_W-1:0] s1_centre_q;
  logic             fwd_q, fwd_d;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic [PIX_W-1:0] upper_rd, middle_rd, up_eff, mid_eff;

  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  // the item leaving stage 1 writes the same column this item reads
  assign fwd_d      = s1_fire && (s1_x_q == x0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q      <= x0;
      s1_r_q      <= r0;
      s1_pix_q    <= pix_i.grey_level;
      s1_emit_q   <= emit0;
      s1_centre_q <= centre0;
      fwd_q       <= fwd_d;
      fwd_up_q    <= mid_eff;
      fwd_mid_q   <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------
  // line stores: upper holds row r-2, middle holds row r-1
  // ---------------------------------------------------------------
  sobv_line_store #(.DEPTH(LINE_DEPTH), .ADDR_W(ADDR_W)) u_upper (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (x0[ADDR_W-1:0]),
    .rd_data_o (upper_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_x_q[ADDR_W-1:0]),
    .wr_data_i (mid_eff)
  );

  sobv_line_store #(.DEPTH(LINE_DEPTH), .ADDR_W(ADDR_W)) u_middle (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (x0[ADDR_W-1:0]),
    .rd_data_o (middle_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_x_q[ADDR_W-1:0]),
    .wr_data_i (s1_pix_q)
  );

  assign up_eff  = fwd_q ? fwd_up_q  : upper_rd;
  assign mid_eff = fwd_q ? fwd_mid_q : middle_rd;

  // ---------------------------------------------------------------
  // window: cell 0 is column x-1, cell 1 is column x-2
  // ---------------------------------------------------------------
  tap_t tap_new, tap0, tap1;

  assign tap_new.up   = up_eff;
  assign tap_new.down = s1_pix_q;

  sobv_tap_cell u_tap0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .tap_i   (tap_new),
    .tap_o   (tap0)
  );

  sobv_tap_cell u_tap1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .tap_i   (tap0),
    .tap_o   (tap1)
  );

  // ---------------------------------------------------------------
  // gradient (8-bit wrapping), border and range checks
  // ---------------------------------------------------------------
  logic [PIX_W-1:0]   sum;
  logic               interior, in_range, wr_ok;
  logic [LEN_W:0]     range_end;

  always_comb begin
    sum = tap0.up + tap0.up + tap1.up + up_eff
        - tap0.down - tap0.down - tap1.down - s1_pix_q;
    interior = (s1_r_q >= DIM_W'(2)) && (s1_r_q <= height_q - DIM_W'(1))
            && (s1_x_q >= DIM_W'(2)) && (s1_x_q <= width_q - DIM_W'(1));
    range_end = {2'b00, start_q} + {1'b0, length_q};
    in_range  = (s1_centre_q >= start_q) && ({2'b00, s1_centre_q} < range_end);
    wr_ok     = interior && in_range;
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  logic [IDX_W-1:0] out_idx_q;
  logic [PIX_W-1:0] out_grad_q;
  logic             out_wr_q;

  always_comb begin
    if (s1_fire && s1_emit_q) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out_idx_q  <= s1_centre_q;
      out_grad_q <= wr_ok ? sum : '0;
      out_wr_q   <= wr_ok;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.pixel_index   = out_idx_q;
  assign res_o.gradient_byte = out_grad_q;
  assign res_o.written       = out_wr_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !res_o.ready) |-> !pix_i.ready)
    else $error("input taken while the compute stage is blocked");

  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.written) |-> (res_o.gradient_byte == '0))
    else $error("gradient byte not zero for an unwritten pixel");

  a_written_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.written) |-> (res_o.pixel_index >= start_q))
    else $error("written pixel below the range start");

  a_fwd_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (fwd_q == ($past(s1_fire) && ($past(s1_x_q) == s1_x_q))))
    else $error("line store bypass does not match the previous column");

endmodule

>>> design/sobv_tap_cell.sv
// sobv_tap_cell: one column of the 2-row window, passed on to its neighbor
// depends on sobv_pkg for tap_t
module sobv_tap_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  sobv_pkg::tap_t tap_i,
  output sobv_pkg::tap_t tap_o
);
  import sobv_pkg::*;

  tap_t tap_q;
  tap_t tap_d;

  assign tap_d = shift_i ? tap_i : tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

>>> design/sobv_line_store.sv
// sobv_line_store: one row of pixels, one write and one registered read per cycle
// depends on sobv_pkg for the pixel width
module sobv_line_store #(
  parameter int unsigned DEPTH  = sobv_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  output logic [sobv_pkg::PIX_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [sobv_pkg::PIX_W-1:0] wr_data_i
);
  import sobv_pkg::*;

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read-during-write at one address returns the old entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for the streaming vertical sobel gradient block
// holds a scoreboard class that predicts each result item and plain drive tasks
// depends on sobv_pkg, sobv_if and sobel_vertical_gradient_stream
`timescale 1ns / 100ps

import sobv_pkg::*;

typedef struct packed {
  logic [IDX_W-1:0] pixel_index;
  logic [PIX_W-1:0] gradient_byte;
  logic             written;
} gradient_item_t;

class gradient_predictor;
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic [IDX_W-1:0] first_idx;
  logic [LEN_W-1:0] idx_span;

  logic [PIX_W-1:0] line_two_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_one_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] up_l, up_ll, dn_l, dn_ll;
  logic [IDX_W-1:0] pix_seq;
  int unsigned      col_pos;
  int unsigned      row_pos;

  gradient_item_t   expected_q[$];
  int unsigned      mismatches;

  function new();
    width_cfg  = DEF_WIDTH;
    height_cfg = DEF_HEIGHT;
    first_idx  = DEF_START;
    idx_span   = DEF_LENGTH;
    foreach (line_two_up[i]) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    up_l       = '0;
    up_ll      = '0;
    dn_l       = '0;
    dn_ll      = '0;
    pix_seq    = '0;
    col_pos    = 0;
    row_pos    = 0;
    mismatches = 0;
  endfunction

  static function int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_WIDTH:  width_cfg  = val[DIM_W-1:0];
      REG_FRAME_HEIGHT: height_cfg = val[DIM_W-1:0];
      REG_RANGE_START:  first_idx  = val[IDX_W-1:0];
      REG_RANGE_LENGTH: idx_span   = val[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_pixel(logic [PIX_W-1:0] grey, logic fs);
    int unsigned      w, h, x, r;
    logic [PIX_W-1:0] up, grad;
    logic [IDX_W-1:0] centre;
    logic [IDX_W+1:0] span_end;
    logic             emit, interior, in_span;
    gradient_item_t   item;
    w = fit_dim(width_cfg, MAX_WIDTH_DEF);
    h = fit_dim(height_cfg, MAX_HEIGHT_DEF);
    if (fs) begin
      pix_seq = '0;
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunk width can leave the column past the end: new row
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < ROW_SAT) row_pos++;
    end
    x  = col_pos;
    r  = row_pos;
    up = line_two_up[x];
    grad = PIX_W'(2 * up_l + up_ll + up - 2 * dn_l - dn_ll - grey);
    emit     = (r >= 2) || (r == 1 && x >= 1);
    centre   = IDX_W'(pix_seq - w - 1);
    interior = (r >= 2) && (r <= h - 1) && (x >= 2) && (x <= w - 1);
    span_end = (IDX_W+2)'(first_idx) + (IDX_W+2)'(idx_span);
    in_span  = (centre >= first_idx) && ((IDX_W+2)'(centre) < span_end);
    line_two_up[x] = line_one_up[x];
    line_one_up[x] = grey;
    up_ll   = up_l;
    up_l    = up;
    dn_ll   = dn_l;
    dn_l    = grey;
    pix_seq = pix_seq + 1'b1;
    col_pos = x + 1;
    if (emit) begin
      item.pixel_index   = centre;
      item.written       = interior && in_span;
      item.gradient_byte = item.written ? grad : '0;
      expected_q.push_back(item);
    end
  endfunction

  task report(string what);
    if (mismatches < 200) $display("MISMATCH %s", what);
    mismatches++;
  endtask

  task match_result(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] grad, logic wr);
    gradient_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result for index %0d with none outstanding", idx));
      return;
    end
    want = expected_q.pop_front();
    if (idx !== want.pixel_index)
      report($sformatf("pixel_index %0d, want %0d", idx, want.pixel_index));
    if (grad !== want.gradient_byte)
      report($sformatf("index %0d gradient_byte %0d, want %0d", want.pixel_index, grad,
                       want.gradient_byte));
    if (wr !== want.written)
      report($sformatf("index %0d written %0b, want %0b", want.pixel_index, wr, want.written));
  endtask

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned RAND_ITEMS  = 340;
  localparam int unsigned QUIET_FROM  = 240;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sobv_pix_if pix_if();
  sobv_res_if res_if();

  gradient_predictor pred;

  // idle controls, changed per phase by the stimulus
  logic        src_idle_on;
  logic        snk_idle_on;
  int unsigned stall_left;
  int unsigned cycle_count;

  sobel_vertical_gradient_stream u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // global watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: when enabled, ready drops at random and stays low while stall_left runs down
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= (stall_left == 1);
      end else if (snk_idle_on && $urandom_range(0, 6) == 0) begin
        res_if.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 10);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor: results are checked before the pixel accepted at the same edge
  // is noted, since a pixel goes through stage 1 and the output register first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        pred.match_result(res_if.pixel_index, res_if.gradient_byte, res_if.written);
      if (pix_if.valid && pix_if.ready)
        pred.take_pixel(pix_if.grey_level, pix_if.frame_start);
    end
  end

  // one pixel item, with an optional gap in front of it
  task automatic send_pixel(input logic [PIX_W-1:0] grey, input logic fs);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.grey_level  <= grey;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // single register write, the enable is lowered by the caller
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    @(posedge clk_i);
    pred.write_reg(idx, CFG_DATA_W'(val));
  endtask

  // write the registers selected by mask: width, height, start, length
  task automatic program_regs(input int unsigned w, input int unsigned h,
                              input int unsigned s, input int unsigned l,
                              input logic [3:0] mask);
    if (mask[0]) put_reg(REG_FRAME_WIDTH, w);
    if (mask[1]) put_reg(REG_FRAME_HEIGHT, h);
    if (mask[2]) put_reg(REG_RANGE_START, s);
    if (mask[3]) put_reg(REG_RANGE_LENGTH, l);
    if (mask != 4'b0000) cfg_we_i <= 1'b0;
  endtask

  // stop sending, wait for every outstanding result and let the pipe empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    pix_if.valid <= 1'b0;
    while (pred.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // grey values lean toward the extremes so the byte wraps both ways
  function automatic logic [PIX_W-1:0] pick_grey();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [PIX_W-1:0] row_one [5];
    int unsigned      i, n, rand_items, w_eff, h_eff, area;
    int unsigned      nw, nh, ns, nl;
    logic [3:0]       mask;
    logic             keep_going;

    pred = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_FRAME_WIDTH;
    cfg_data_i         = '0;
    pix_if.valid       = 1'b0;
    pix_if.grey_level  = '0;
    pix_if.frame_start = 1'b0;
    res_if.ready       = 1'b0;
    src_idle_on        = 1'b0;
    snk_idle_on        = 1'b0;
    stall_left         = 0;
    cycle_count        = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed 5x4 frame: full-scale positive then negative gradient
    program_regs(5, 4, 0, DEF_LENGTH, 4'b1111);
    row_one = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
    for (i = 0; i < 5; i++) send_pixel(8'd255, i == 0);
    for (i = 0; i < 5; i++) send_pixel(row_one[i], 1'b0);
    for (i = 0; i < 5; i++) send_pixel(8'd0, 1'b0);
    for (i = 0; i < 5; i++) send_pixel(8'd255, 1'b0);
    settle();

    // widest clamp: width above the maximum, height below the minimum;
    // only reaches the second row, so every result is unwritten
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    program_regs(2047, 0, 0, 0, 4'b0011);
    for (i = 0; i < 1031; i++) send_pixel(pick_grey(), i == 0);
    settle();

    // smallest frame streamed well past its end: later rows are unwritten
    program_regs(0, 1, 0, DEF_LENGTH, 4'b0011);
    for (i = 0; i < 3 * 20; i++) send_pixel(pick_grey(), i == 0);
    settle();

    // random phases: mostly whole small frames, some continued streams
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      keep_going = ($urandom_range(0, 3) == 0);
      mask       = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       nw = 0;
        1:       nw = 1;
        2:       nw = 2;
        3:       nw = 3;
        default: nw = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       nh = 0;
        1:       nh = 1;
        2:       nh = 2;
        3:       nh = 2047;
        4:       nh = 1024;
        default: nh = $urandom_range(3, 8);
      endcase
      area = pred.fit_dim(DIM_W'(nw), MAX_WIDTH_DEF) * 8;
      case ($urandom_range(0, 5))
        0:       ns = 0;
        1:       ns = $urandom_range(0, area);
        2:       ns = 20'hFFFFF;
        3:       ns = $urandom_range(0, 20'hFFFFF);
        default: ns = $urandom_range(0, area / 2);
      endcase
      case ($urandom_range(0, 6))
        0:       nl = 0;
        1:       nl = 1;
        2:       nl = DEF_LENGTH;
        3:       nl = 21'h1FFFFF;
        4:       nl = $urandom_range(0, 21'h1FFFFF);
        default: nl = $urandom_range(0, area);
      endcase
      // a wider row would read line store entries never filled: restart frame
      if (keep_going && mask[0] &&
          pred.fit_dim(DIM_W'(nw), MAX_WIDTH_DEF) >
          pred.fit_dim(pred.width_cfg, MAX_WIDTH_DEF))
        keep_going = 1'b0;
      program_regs(nw, nh, ns, nl, mask);

      if (rand_items >= QUIET_FROM) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 2) != 0);
        snk_idle_on = ($urandom_range(0, 2) != 0);
      end

      w_eff = pred.fit_dim(pred.width_cfg, MAX_WIDTH_DEF);
      h_eff = pred.fit_dim(pred.height_cfg, MAX_HEIGHT_DEF);
      if (keep_going) begin
        n = $urandom_range(5, 60);
      end else begin
        n = w_eff * h_eff + $urandom_range(0, 2 * w_eff);
        if (n > 240) n = $urandom_range(60, 240);
      end
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      // rare stray frame marks land mid-frame
      for (i = 0; i < n; i++)
        send_pixel(pick_grey(), (i == 0 && !keep_going) || $urandom_range(0, 299) == 0);
      rand_items += n;
      settle();
    end

    // final drain, anything still outstanding never came
    settle();
    repeat (16) @(posedge clk_i);
    if (pred.pending() != 0)
      pred.report($sformatf("%0d results never arrived", pred.pending()));

    if (pred.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/sobv_pkg.sv
design/sobv_if.sv
design/sobv_tap_cell.sv
design/sobv_line_store.sv
design/sobel_vertical_gradient_stream.sv
dv/tb_top.sv
